/* hw/rtl/lcacc_pkg.sv */
// shared types and constants for the label centroid accumulator
// used by the accumulator, lcacc_mem and lcacc_div; depends on nothing
package lcacc_pkg;

    localparam int FUNC_W     = 2;
    localparam int LABEL_W    = 8;
    localparam int COORD_W    = 10;
    localparam int CFG_W      = 8;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = 31;
    localparam int CTR_W      = 18;
    localparam int FRAC_W     = 8;
    localparam int SAT_SHIFT  = CTR_W - FRAC_W;
    localparam int DIN_W      = 40;
    localparam int DOUT_W     = 88;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = 31'h4000_0000;
    localparam logic [CTR_W-1:0] CENTER_MAX  = '1;
    localparam logic [CFG_W-1:0] GRAIN_RESET = 8'd255;

    typedef enum logic [FUNC_W-1:0] {
        FN_ACC   = 2'd0,
        FN_READ  = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_z;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic [CTR_W-1:0] cz;
    } t_center;

endpackage

/* hw/rtl/label_centroid_accumulator.sv */
// Label centroid accumulator. Per grain label the block keeps x, y and slice
// sums and a voxel count in one on-chip store (one read, one write port).
// Accumulate and clear requests are accepted back to back: the store is read
// when a request is accepted and written in the next cycle, with the last
// write forwarded to a request on the same label. A read request runs the
// three-lane divider, one quotient bit a cycle, and holds off new requests
// through its execute cycle, 18 quotient steps and the hand-off to the output
// register, and longer while an earlier result still waits in that register.
// After reset the store is zeroed in a pass over all MAX_GRAINS entries during
// which no request is accepted; grain_count writes are taken at any time.
// depends on lcacc_pkg, lcacc_mem and lcacc_div
module label_centroid_accumulator #(
    parameter int MAX_GRAINS = 256,
    parameter int COORD_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write: grain_count
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lcacc_pkg::CFG_W-1:0]   i_cfg_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // label[7:0], coord_x[17:8], coord_y[27:18], slice[37:28], zero pad
    input  logic [lcacc_pkg::DIN_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  logic [lcacc_pkg::FUNC_W-1:0]  s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // center_x[17:0], center_y[35:18], center_z[53:36],
    // voxels_seen[84:54], present[85], zero pad
    output logic [lcacc_pkg::DOUT_W-1:0]  m_axis_tdata
);

    localparam int AW = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam int EFF_BITS = (COORD_BITS < lcacc_pkg::COORD_W) ?
                              COORD_BITS : lcacc_pkg::COORD_W;
    localparam logic [lcacc_pkg::COORD_W-1:0] COORD_MASK =
        lcacc_pkg::COORD_W'((32'd1 << EFF_BITS) - 32'd1);

    // request fields
    logic [lcacc_pkg::LABEL_W-1:0] in_label;
    logic [lcacc_pkg::COORD_W-1:0] in_x, in_y, in_z;
    logic                          in_store, accept;
    lcacc_pkg::t_func              in_func;

    assign in_label = s_axis_tdata[7:0];
    assign in_x     = s_axis_tdata[17:8]  & COORD_MASK;
    assign in_y     = s_axis_tdata[27:18] & COORD_MASK;
    assign in_z     = s_axis_tdata[37:28] & COORD_MASK;
    assign in_func  = lcacc_pkg::t_func'(s_axis_tuser);
    assign in_store = (32'(in_label) < MAX_GRAINS);
    assign accept   = s_axis_tvalid && s_axis_tready;

    // config register
    logic [lcacc_pkg::CFG_W-1:0] r_grain_count;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grain_count <= lcacc_pkg::GRAIN_RESET;
        end else if (i_cfg_valid) begin
            r_grain_count <= i_cfg_data;
        end
    end

    // clearing pass after reset
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_GRAINS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // execute stage, the cycle after acceptance
    logic                          r_b_valid;
    lcacc_pkg::t_func              r_b_func;
    logic [AW-1:0]                 r_b_addr;
    logic                          r_b_store, r_b_acc_ok;
    logic [lcacc_pkg::COORD_W-1:0] r_b_x, r_b_y, r_b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_func   <= in_func;
            r_b_addr   <= AW'(in_label);
            r_b_store  <= in_store;
            r_b_acc_ok <= in_store && (in_label != '0) && (in_label <= r_grain_count);
            r_b_x      <= in_x;
            r_b_y      <= in_y;
            r_b_z      <= in_z;
        end
    end

    // store and forwarding of the previous write
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    lcacc_pkg::t_entry wr_data, rd_data, cur, upd;
    logic              r_fw_valid;
    logic [AW-1:0]     r_fw_addr;
    lcacc_pkg::t_entry r_fw_data;

    lcacc_mem #(
        .DEPTH (MAX_GRAINS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(in_label)),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= wr_addr;
        r_fw_data <= wr_data;
    end

    assign cur = (r_fw_valid && (r_fw_addr == r_b_addr)) ? r_fw_data : rd_data;

    // read-modify-write of the addressed entry, clear requests and the clearing pass
    always_comb begin
        upd.sum_x = cur.sum_x + lcacc_pkg::SUM_W'(r_b_x);
        upd.sum_y = cur.sum_y + lcacc_pkg::SUM_W'(r_b_y);
        upd.sum_z = cur.sum_z + lcacc_pkg::SUM_W'(r_b_z);
        upd.count = cur.count + 1'b1;
        wr_en     = 1'b0;
        wr_addr   = r_b_addr;
        wr_data   = upd;
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else if (r_b_valid && (r_b_func == lcacc_pkg::FN_ACC) && r_b_acc_ok &&
                     (cur.count < lcacc_pkg::COUNT_LIMIT)) begin
            wr_en = 1'b1;
        end else if (r_b_valid && (r_b_func == lcacc_pkg::FN_CLEAR) && r_b_store) begin
            wr_en   = 1'b1;
            wr_data = '0;
        end
    end

    // centroid division for read requests
    logic                         div_start, div_done, div_take;
    lcacc_pkg::t_entry            div_opnd;
    lcacc_pkg::t_center           div_res;
    logic [lcacc_pkg::CNT_W-1:0]  r_cnt_hold;
    logic                         r_div_busy;

    assign div_start = r_b_valid && (r_b_func == lcacc_pkg::FN_READ);
    assign div_opnd  = r_b_store ? cur : '0;

    lcacc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_opnd  (div_opnd),
        .i_take  (div_take),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (div_start) begin
            r_div_busy <= 1'b1;
        end else if (div_take) begin
            r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_cnt_hold <= div_opnd.count;
        end
    end

    // output register
    logic                          r_out_valid;
    logic [lcacc_pkg::DOUT_W-1:0]  r_out_data;

    assign div_take = div_done && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_take) begin
            r_out_data <= {2'b00, (r_cnt_hold != '0), r_cnt_hold,
                           div_res.cz, div_res.cy, div_res.cx};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // requests wait during the clearing pass and while a read is in flight
    assign s_axis_tready = !r_clearing && !div_start && !r_div_busy &&
                           !(r_b_valid && (r_b_func == lcacc_pkg::FN_READ));

endmodule

/* hw/rtl/lcacc_mem.sv */
// per-label accumulator store: one write port, one read port, registered read
// depends on lcacc_pkg for the entry type
module lcacc_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  lcacc_pkg::t_entry     i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output lcacc_pkg::t_entry     o_rd_data
);

    lcacc_pkg::t_entry r_mem [DEPTH];
    lcacc_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/lcacc_div.sv */
// three-lane restoring divider for the centroid, one quotient bit per cycle
// depends on lcacc_pkg for entry, result and state types
module lcacc_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  lcacc_pkg::t_entry     i_opnd,
    input  logic                  i_take,
    output logic                  o_done,
    output lcacc_pkg::t_center    o_res
);

    localparam int CW = $clog2(lcacc_pkg::CTR_W);

    lcacc_pkg::t_div_state r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [lcacc_pkg::CNT_W-1:0]   r_n, n_n;
    logic                          r_zero, n_zero;
    logic [lcacc_pkg::CNT_W-1:0]   r_rem [3];
    logic [lcacc_pkg::CNT_W-1:0]   n_rem [3];
    logic [lcacc_pkg::CTR_W-1:0]   r_dlo [3];
    logic [lcacc_pkg::CTR_W-1:0]   n_dlo [3];
    logic [lcacc_pkg::CTR_W-1:0]   r_q   [3];
    logic [lcacc_pkg::CTR_W-1:0]   n_q   [3];
    logic                          r_sat [3];
    logic                          n_sat [3];
    logic [lcacc_pkg::SUM_W-1:0]   sums  [3];
    logic [lcacc_pkg::CTR_W-1:0]   lane  [3];
    logic [lcacc_pkg::CNT_W:0]     trial [3];

    assign sums[0] = i_opnd.sum_x;
    assign sums[1] = i_opnd.sum_y;
    assign sums[2] = i_opnd.sum_z;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcacc_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_n    <= n_n;
        r_zero <= n_zero;
        for (int l = 0; l < 3; l++) begin
            r_rem[l] <= n_rem[l];
            r_dlo[l] <= n_dlo[l];
            r_q[l]   <= n_q[l];
            r_sat[l] <= n_sat[l];
        end
    end

    // next state and lane steps
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_zero  = r_zero;
        for (int l = 0; l < 3; l++) begin
            n_rem[l] = r_rem[l];
            n_dlo[l] = r_dlo[l];
            n_q[l]   = r_q[l];
            n_sat[l] = r_sat[l];
            trial[l] = {r_rem[l], r_dlo[l][lcacc_pkg::CTR_W-1]};
        end
        unique case (r_state)
            lcacc_pkg::DIV_IDLE: begin
                if (i_start) begin
                    n_state = lcacc_pkg::DIV_RUN;
                    n_cnt   = '0;
                    n_n     = i_opnd.count;
                    n_zero  = (i_opnd.count == '0);
                    for (int l = 0; l < 3; l++) begin
                        // the quotient overflows 18 bits when sum >= count * 2^10
                        n_sat[l] = ({1'b0, sums[l]} >=
                                    {i_opnd.count, {lcacc_pkg::SAT_SHIFT{1'b0}}});
                        n_rem[l] = lcacc_pkg::CNT_W'(sums[l] >> lcacc_pkg::SAT_SHIFT);
                        n_dlo[l] = {sums[l][lcacc_pkg::SAT_SHIFT-1:0],
                                    {lcacc_pkg::FRAC_W{1'b0}}};
                        n_q[l]   = '0;
                    end
                end
            end
            lcacc_pkg::DIV_RUN: begin
                for (int l = 0; l < 3; l++) begin
                    if (trial[l] >= {1'b0, r_n}) begin
                        n_rem[l] = lcacc_pkg::CNT_W'(trial[l] - {1'b0, r_n});
                        n_q[l]   = {r_q[l][lcacc_pkg::CTR_W-2:0], 1'b1};
                    end else begin
                        n_rem[l] = trial[l][lcacc_pkg::CNT_W-1:0];
                        n_q[l]   = {r_q[l][lcacc_pkg::CTR_W-2:0], 1'b0};
                    end
                    n_dlo[l] = {r_dlo[l][lcacc_pkg::CTR_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(lcacc_pkg::CTR_W - 1)) begin
                    n_state = lcacc_pkg::DIV_DONE;
                end
            end
            lcacc_pkg::DIV_DONE: begin
                if (i_take) begin
                    n_state = lcacc_pkg::DIV_IDLE;
                end
            end
            default: begin
                n_state = lcacc_pkg::DIV_IDLE;
            end
        endcase
    end

    // empty entry gives zero, overflow saturates
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (r_zero) begin
                lane[l] = '0;
            end else if (r_sat[l]) begin
                lane[l] = lcacc_pkg::CENTER_MAX;
            end else begin
                lane[l] = r_q[l];
            end
        end
    end

    assign o_res.cx = lane[0];
    assign o_res.cy = lane[1];
    assign o_res.cz = lane[2];
    assign o_done   = (r_state == lcacc_pkg::DIV_DONE);

endmodule

/* hw/rtl/lcacc_checker.sv */
// port-level checks for the label centroid accumulator, bound to the top level
// depends on label_centroid_accumulator port names only
module lcacc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // present flag matches the count
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[85] == (m_axis_tdata[84:54] != 31'd0)))
        else $error("present flag disagrees with count");

    // an empty entry gives a zero centroid
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[84:54] == 31'd0)) |-> (m_axis_tdata[53:0] == 54'd0))
        else $error("centroid of empty label not zero");

    // reset starts the clearing pass with no request taken and no result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!s_axis_tready && !m_axis_tvalid))
        else $error("block active right after reset");

endmodule

bind label_centroid_accumulator lcacc_checker u_lcacc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
